/* src/csvfs_pkg.sv */
package csvfs_pkg;

   // Character and count widths of the tokenizer core.
   localparam int CHAR_BITS  = 16;
   localparam int COUNT_BITS = 16;

   // Width of the fixed character ports and registers.
   localparam int PORT_CHAR_BITS = 16;
   localparam int CSR_INDEX_BITS = 1;

   // Mask that keeps the compared low bits of a port-width character.
   localparam logic [PORT_CHAR_BITS-1:0] CHAR_MASK =
      (CHAR_BITS >= PORT_CHAR_BITS) ? {PORT_CHAR_BITS{1'b1}} :
      PORT_CHAR_BITS'((64'd1 << CHAR_BITS) - 64'd1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [PORT_CHAR_BITS-1:0] SEPARATOR_RESET = 16'd44;
   localparam logic [PORT_CHAR_BITS-1:0] QUOTE_RESET     = 16'd34;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SEPARATOR = 1'b0,
      CSR_QUOTE     = 1'b1
   } csr_index_type;

   // Per-line parser state.
   typedef struct packed {
      logic                  at_field_start;
      logic                  in_quotes;
      logic                  quote_pending;
      logic [COUNT_BITS-1:0] separator_tally;
   } line_state_type;

   // One result item.
   typedef struct packed {
      logic [PORT_CHAR_BITS-1:0] out_char;
      logic                      char_valid;
      logic                      field_done;
      logic                      line_done;
      logic [PORT_CHAR_BITS-1:0] field_count;
   } result_type;

   localparam line_state_type LINE_STATE_RESET = '{
      at_field_start:  1'b1,
      in_quotes:       1'b0,
      quote_pending:   1'b0,
      separator_tally: '0
   };

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_BITS'(1);
   endfunction

endpackage

/* src/csv_field_splitter.sv */
// CSV field splitter. The block takes one character of a text line per
// transfer on the req_ channel and returns exactly one result transfer on the
// rsp_ channel for each, in order. A quote character that opens a field
// starts a quoted string and is dropped; inside the string the separator is
// plain data, a doubled quote yields one literal quote and a single quote
// closes the string. Each result carries the data character (if any), a
// field_done flag for an unquoted separator, and on the character marked
// line_last a line_done flag with the saturating field count, after which
// the parser returns to its start-of-line state. Each accepted character
// yields a registered result, and a new character is accepted in every
// cycle while the result register is empty or being drained in
// the same cycle. The separator and quote codes are written
// through the csr_ port, which is always ready, and should only be changed
// while no line is in flight.
module csv_field_splitter
   import csvfs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [PORT_CHAR_BITS-1:0]  csr_data,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [PORT_CHAR_BITS-1:0]  req_in_char,
   input  logic                       req_line_last,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [PORT_CHAR_BITS-1:0]  rsp_out_char,
   output logic                       rsp_char_valid,
   output logic                       rsp_field_done,
   output logic                       rsp_line_done,
   output logic [PORT_CHAR_BITS-1:0]  rsp_field_count
);

   logic [PORT_CHAR_BITS-1:0] separator_ff;
   logic [PORT_CHAR_BITS-1:0] quote_ff;
   line_state_type            state_ff;
   line_state_type            state_in;
   result_type                result_in;
   result_type                result_ff;
   logic                      rsp_valid_ff;
   logic                      req_fire;

   // Configuration writes are always accepted.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff <= SEPARATOR_RESET;
         quote_ff     <= QUOTE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_SEPARATOR: separator_ff <= csr_data;
            CSR_QUOTE:     quote_ff     <= csr_data;
            default:       ;
         endcase
      end
   end

   // The result register can take a new item when it is empty or drains now.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   csvfs_step u_step (
      .state          (state_ff),
      .in_char        (req_in_char),
      .line_last      (req_line_last),
      .separator_char (separator_ff),
      .quote_char     (quote_ff),
      .state_next     (state_in),
      .result         (result_in)
   );

   // Parser state advances on every accepted character.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LINE_STATE_RESET;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // The result payload needs no reset; it is qualified by rsp_valid.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = result_ff.out_char;
   assign rsp_char_valid  = result_ff.char_valid;
   assign rsp_field_done  = result_ff.field_done;
   assign rsp_line_done   = result_ff.line_done;
   assign rsp_field_count = result_ff.field_count;

   // The last character of a line always leaves the parser at line start.
   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_line_last |=> state_ff == LINE_STATE_RESET)
      else $error("parser state not cleared after line end");

   // A pending quote only exists inside a quoted string.
   a_pending_in_quotes: assert property (@(posedge clock) disable iff (reset)
      state_ff.quote_pending |-> state_ff.in_quotes && !state_ff.at_field_start)
      else $error("quote pending outside a quoted string");

   // A registered result holds a data character or a separator, never both.
   a_char_or_sep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(result_ff.char_valid && result_ff.field_done))
      else $error("result marks both data and separator");

   // An accepted character shows up as a result in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted character produced no result");

endmodule

/* src/csvfs_step.sv */
module csvfs_step
   import csvfs_pkg::*;
(
   input  line_state_type             state,
   input  logic [PORT_CHAR_BITS-1:0]  in_char,
   input  logic                       line_last,
   input  logic [PORT_CHAR_BITS-1:0]  separator_char,
   input  logic [PORT_CHAR_BITS-1:0]  quote_char,
   output line_state_type             state_next,
   output result_type                 result
);

   logic [PORT_CHAR_BITS-1:0] c;
   logic                      is_quote;
   logic                      is_sep;
   logic                      plain;
   logic [COUNT_BITS-1:0]     line_count;

   assign c        = in_char & CHAR_MASK;
   assign is_quote = (c == (quote_char & CHAR_MASK));
   assign is_sep   = (c == (separator_char & CHAR_MASK));

   always_comb begin
      state_next = state;
      result     = '0;
      plain      = 1'b0;

      // A quote inside a string is decided by the character after it.
      if (state.quote_pending) begin
         state_next.quote_pending = 1'b0;
         if (is_quote) begin
            result.out_char   = c;
            result.char_valid = 1'b1;
         end else begin
            state_next.in_quotes = 1'b0;
            plain                = 1'b1;
         end
      end else if (state.at_field_start) begin
         state_next.at_field_start = 1'b0;
         if (is_quote) begin
            state_next.in_quotes = 1'b1;
         end else begin
            plain = 1'b1;
         end
      end else if (state.in_quotes) begin
         if (is_quote) begin
            state_next.quote_pending = 1'b1;
         end else begin
            result.out_char   = c;
            result.char_valid = 1'b1;
         end
      end else begin
         plain = 1'b1;
      end

      if (plain) begin
         if (is_sep) begin
            result.field_done          = 1'b1;
            state_next.separator_tally = sat_inc(state.separator_tally);
            state_next.at_field_start  = 1'b1;
         end else begin
            result.out_char   = c;
            result.char_valid = 1'b1;
         end
      end

      line_count = sat_inc(state_next.separator_tally);
      if (line_last) begin
         result.line_done   = 1'b1;
         result.field_count = PORT_CHAR_BITS'(line_count);
         state_next         = LINE_STATE_RESET;
      end
   end

endmodule
